@@ sv/rcd_pkg.sv @@
package rcd_pkg;

	localparam int WORD_W    = 32;
	localparam int CMD_W     = 3;
	localparam int ST_W      = 2;
	localparam int OCC_W     = 5;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_R  = 3'd0,
		CMD_INS_L  = 3'd1,
		CMD_DEL_L  = 3'd2,
		CMD_DEL_R  = 3'd3,
		CMD_PEEK_L = 3'd4,
		CMD_PEEK_R = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_FORBIDDEN = 2'd3
	} status_t;

	// restrict_mode encodings
	localparam logic MODE_IN_RESTR  = 1'b0;
	localparam logic MODE_OUT_RESTR = 1'b1;

	typedef struct packed {
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
		logic              is_empty;
		logic              is_full;
		logic              rd_sel;
	} res_t;

endpackage

@@ sv/rcd_if.sv @@
interface rcd_req_if;
	logic                               valid;
	logic                               ready;
	logic [rcd_pkg::CMD_W-1:0]          cmd;
	logic signed [rcd_pkg::WORD_W-1:0]  value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rcd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [rcd_pkg::WORD_W-1:0]  data;
	logic [rcd_pkg::ST_W-1:0]           status;
	logic [rcd_pkg::OCC_W-1:0]          occupancy;
	logic                               is_empty;
	logic                               is_full;

	modport source (output valid, output data, output status, output occupancy,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input data, input status, input occupancy,
		input is_empty, input is_full, output ready);
endinterface

interface rcd_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rcd_mem.sv @@
module rcd_mem #(
	parameter int DEPTH = rcd_pkg::DEPTH_DEF,
	parameter int W     = rcd_pkg::WORD_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/rcd_ctrl.sv @@
module rcd_ctrl #(
	parameter int DEPTH = rcd_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic                        mode,
	input  logic [rcd_pkg::CMD_W-1:0]   cmd,
	input  logic [rcd_pkg::WORD_W-1:0]  value,
	output logic                        we,
	output logic [AW-1:0]               waddr,
	output logic [rcd_pkg::WORD_W-1:0]  wdata,
	output logic                        re,
	output logic [AW-1:0]               raddr,
	output rcd_pkg::res_t               res
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] front_q, rear_q, front_nx, rear_nx;
	logic          empty_q, empty_nx;
	logic          wr_en, rd_en;
	logic [CW-1:0] cnt_now, cnt_nx;

	function automatic logic [CW-1:0] count_of(logic [AW-1:0] f, logic [AW-1:0] r,
		logic e);
		logic [CW-1:0] d;
		if (r >= f) begin
			d = CW'(r) - CW'(f);
		end else begin
			d = CW'(r) + CW'(DEPTH) - CW'(f);
		end
		return e ? '0 : d + CW'(1);
	endfunction

	function automatic logic [AW-1:0] step_up(logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_down(logic [AW-1:0] i);
		return (i == '0) ? LAST : i - AW'(1);
	endfunction

	assign cnt_now = count_of(front_q, rear_q, empty_q);

	always_comb begin
		logic forbidden, ins, del, left;
		forbidden  = 1'b0;
		ins        = 1'b0;
		del        = 1'b0;
		left       = 1'b0;
		unique case (rcd_pkg::cmd_t'(cmd))
			rcd_pkg::CMD_INS_R: begin
				ins = 1'b1;
			end
			rcd_pkg::CMD_INS_L: begin
				ins       = 1'b1;
				left      = 1'b1;
				forbidden = (mode == rcd_pkg::MODE_IN_RESTR);
			end
			rcd_pkg::CMD_DEL_L: begin
				del  = 1'b1;
				left = 1'b1;
			end
			rcd_pkg::CMD_DEL_R: begin
				del       = 1'b1;
				forbidden = (mode == rcd_pkg::MODE_OUT_RESTR);
			end
			rcd_pkg::CMD_PEEK_L: begin
				left = 1'b1;
			end
			rcd_pkg::CMD_PEEK_R: begin
			end
			default: begin
				forbidden = 1'b1;
			end
		endcase

		front_nx   = front_q;
		rear_nx    = rear_q;
		empty_nx   = empty_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		waddr      = '0;
		raddr      = left ? front_q : rear_q;
		res.status = rcd_pkg::ST_OK;

		priority if (forbidden) begin
			res.status = rcd_pkg::ST_FORBIDDEN;
		end else if (ins) begin
			if (cnt_now == CW'(DEPTH)) begin
				res.status = rcd_pkg::ST_OVERFLOW;
			end else begin
				wr_en = 1'b1;
				if (empty_q) begin
					front_nx = '0;
					rear_nx  = '0;
					empty_nx = 1'b0;
					waddr    = '0;
				end else if (left) begin
					front_nx = step_down(front_q);
					waddr    = front_nx;
				end else begin
					rear_nx = step_up(rear_q);
					waddr   = rear_nx;
				end
			end
		end else if (empty_q) begin
			res.status = rcd_pkg::ST_UNDERFLOW;
		end else begin
			rd_en = 1'b1;
			if (del) begin
				if (front_q == rear_q) begin
					front_nx = '0;
					rear_nx  = '0;
					empty_nx = 1'b1;
				end else if (left) begin
					front_nx = step_up(front_q);
				end else begin
					rear_nx = step_down(rear_q);
				end
			end
		end

		cnt_nx        = count_of(front_nx, rear_nx, empty_nx);
		res.occupancy = rcd_pkg::OCC_W'(cnt_nx);
		res.is_empty  = (cnt_nx == '0);
		res.is_full   = (cnt_nx == CW'(DEPTH));
		res.rd_sel    = rd_en;
	end

	assign we    = go && wr_en;
	assign re    = go && rd_en;
	assign wdata = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (go) begin
			front_q <= front_nx;
			rear_q  <= rear_nx;
			empty_q <= empty_nx;
		end
	end

endmodule

@@ sv/restricted_circular_deque.sv @@
// Circular deque of DEPTH signed 32-bit words with insert, delete and peek at
// both ends; every command gives exactly one result with data, status, and the
// occupancy and empty/full flags after the command. A command is taken in any
// cycle in which the result register is empty or its result is being taken, so
// the block sustains one command per clock while results are taken; each result
// appears in the cycle after its command is taken, from the output register and
// the registered read port of the slot memory. restrict_mode (reset 0) selects
// input-restricted use (insert left rejected) or output-restricted use (delete
// right rejected); rejected commands and codes 6 and 7 return status 3 and change
// nothing. Occupancy is reported modulo 32. Slots are not cleared at reset.
module restricted_circular_deque #(
	parameter int DEPTH = rcd_pkg::DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic       clk,
	input  logic       arst_n,
	rcd_req_if.sink    req,
	rcd_rsp_if.source  rsp,
	rcd_cfg_if.sink    cfg
);

	logic                       go;
	logic                       mode_q;
	logic                       valid_q;
	rcd_pkg::res_t              res, res_q;
	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [rcd_pkg::WORD_W-1:0] wdata, rdata;

	assign req.ready = !valid_q || rsp.ready;
	assign go        = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	rcd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.mode   (mode_q),
		.cmd    (req.cmd),
		.value  (req.value),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr  (raddr),
		.res    (res)
	);

	rcd_mem #(.DEPTH(DEPTH), .W(rcd_pkg::WORD_W)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= rcd_pkg::MODE_IN_RESTR;
			valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				mode_q <= cfg.data;
			end
			if (go) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res;
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.data      = res_q.rd_sel ? rdata : '0;
	assign rsp.status    = res_q.status;
	assign rsp.occupancy = res_q.occupancy;
	assign rsp.is_empty  = res_q.is_empty;
	assign rsp.is_full   = res_q.is_full;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> rsp.valid)
		else $error("accepted item gave no result");

	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.is_empty && rsp.is_full))
		else $error("empty and full at once");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_empty |-> rsp.occupancy == '0)
		else $error("empty with nonzero occupancy");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != rcd_pkg::ST_OK |-> rsp.data == '0)
		else $error("error result with nonzero data");

endmodule

@@ verif/deque_checker.sv @@
`timescale 1ns / 1ps

module deque_checker
	import rcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rcd_req_if   req,
	rcd_rsp_if   rsp,
	rcd_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   overflow_cnt,
	output int   underflow_cnt,
	output int   reject_cnt,
	output int   full_cnt
);

	localparam int DEPTH = DEPTH_DEF;
	localparam int IDX_W = $clog2(DEPTH);

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [ST_W-1:0]          status;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     is_full;
	} deque_answer_t;

	logic signed [WORD_W-1:0] ring [DEPTH];
	logic [IDX_W-1:0]         head;
	logic [IDX_W-1:0]         tail;
	logic                     ring_empty;
	logic                     mode_sel;
	deque_answer_t            answers_due[$];

	function automatic logic [OCC_W-1:0] words_held();
		logic [IDX_W-1:0] span;
		span = tail - head;
		if (ring_empty)
			return '0;
		return OCC_W'(span) + OCC_W'(1);
	endfunction

	task automatic apply_deque_cmd(input logic [CMD_W-1:0] op,
		input logic signed [WORD_W-1:0] word, output deque_answer_t ans);
		logic             forbidden;
		logic [OCC_W-1:0] n;
		ans = '0;
		ans.status = ST_OK;
		forbidden = (op > CMD_PEEK_R) ||
			(mode_sel == MODE_IN_RESTR && op == CMD_INS_L) ||
			(mode_sel == MODE_OUT_RESTR && op == CMD_DEL_R);
		n = words_held();
		if (forbidden) begin
			ans.status = ST_FORBIDDEN;
		end else if (op == CMD_INS_R || op == CMD_INS_L) begin
			if (n >= DEPTH) begin
				ans.status = ST_OVERFLOW;
			end else if (ring_empty) begin
				head = '0;
				tail = '0;
				ring_empty = 1'b0;
				ring[0] = word;
			end else if (op == CMD_INS_R) begin
				tail = tail + 1'b1;
				ring[tail] = word;
			end else begin
				head = head - 1'b1;
				ring[head] = word;
			end
		end else if (ring_empty) begin
			ans.status = ST_UNDERFLOW;
		end else if (op == CMD_PEEK_L) begin
			ans.data = ring[head];
		end else if (op == CMD_PEEK_R) begin
			ans.data = ring[tail];
		end else begin
			ans.data = (op == CMD_DEL_L) ? ring[head] : ring[tail];
			if (head == tail) begin
				head = '0;
				tail = '0;
				ring_empty = 1'b1;
			end else if (op == CMD_DEL_L) begin
				head = head + 1'b1;
			end else begin
				tail = tail - 1'b1;
			end
		end
		n = words_held();
		ans.occupancy = n;
		ans.is_empty = (n == 0);
		ans.is_full = (n == DEPTH);
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		checked = 0;
		overflow_cnt = 0;
		underflow_cnt = 0;
		reject_cnt = 0;
		full_cnt = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		deque_answer_t want;
		deque_answer_t fresh;
		if (!arst_n) begin
			head = '0;
			tail = '0;
			ring_empty = 1'b1;
			mode_sel = MODE_IN_RESTR;
			answers_due.delete();
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result with nothing pending", rsp.data, '0);
				end else begin
					want = answers_due.pop_front();
					checked++;
					if (rsp.data !== want.data)
						report_mismatch("data", rsp.data, want.data);
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(rsp.occupancy),
							32'(want.occupancy));
					if (rsp.is_empty !== want.is_empty)
						report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
					if (rsp.is_full !== want.is_full)
						report_mismatch("is_full", 32'(rsp.is_full), 32'(want.is_full));
				end
			end
			if (req.valid && req.ready) begin
				apply_deque_cmd(req.cmd, req.value, fresh);
				answers_due.push_back(fresh);
				if (fresh.status == ST_OVERFLOW)
					overflow_cnt++;
				if (fresh.status == ST_UNDERFLOW)
					underflow_cnt++;
				if (fresh.status == ST_FORBIDDEN)
					reject_cnt++;
				if (fresh.is_full)
					full_cnt++;
			end
			if (cfg.valid && cfg.ready)
				mode_sel = cfg.data;
			pending = answers_due.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import rcd_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
	localparam int PHASE_ITEMS = 306;
	localparam int HOLD_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	bit   hold_rsp;
	int   items_sent;
	int   mode_writes;
	int   fail_count;
	int   pending;
	int   checked;
	int   overflow_cnt;
	int   underflow_cnt;
	int   reject_cnt;
	int   full_cnt;

	rcd_req_if req_ch();
	rcd_rsp_if rsp_ch();
	rcd_cfg_if cfg_ch();

	restricted_circular_deque dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	deque_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.overflow_cnt  (overflow_cnt),
		.underflow_cnt (underflow_cnt),
		.reject_cnt    (reject_cnt),
		.full_cnt      (full_cnt)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("restricted_circular_deque verification failed");
		$finish;
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		int n;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 17);
				rsp_ch.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] word);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.value <= word;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		mode_writes++;
	endtask

	function automatic logic [CMD_W-1:0] pick_cmd(input int ins_pct, input logic m);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
		if (r < 8)
			return (m == MODE_IN_RESTR) ? CMD_INS_L : CMD_DEL_R;
		if (r < 18)
			return $urandom_range(0, 1) ? CMD_PEEK_L : CMD_PEEK_R;
		if ($urandom_range(0, 99) < ins_pct) begin
			if (m == MODE_IN_RESTR)
				return CMD_INS_R;
			return $urandom_range(0, 1) ? CMD_INS_L : CMD_INS_R;
		end
		if (m == MODE_OUT_RESTR)
			return CMD_DEL_L;
		return $urandom_range(0, 1) ? CMD_DEL_L : CMD_DEL_R;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random(input int count, input logic m, input int hold_at);
		int bias;
		write_mode(m);
		bias = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 4))
					0: bias = 85;
					1: bias = 15;
					2: bias = 50;
					3: bias = 92;
					default: bias = 8;
				endcase
			end
			if (i == hold_at) begin
				bias = 85;
				hold_rsp = 1'b1;
			end
			send_cmd(pick_cmd(bias, m), pick_word());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		items_sent = 0;
		mode_writes = 0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INS_R;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = MODE_IN_RESTR;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		write_mode(MODE_IN_RESTR);
		send_cmd(CMD_PEEK_L, 32'h0);
		send_cmd(CMD_PEEK_R, 32'h0);
		send_cmd(CMD_DEL_L, 32'h0);
		send_cmd(CMD_DEL_R, 32'hFFFF_FFFF);
		send_cmd(CMD_INS_L, 32'h1234_5678);
		send_cmd(CMD_RSVD_6, 32'h0);
		send_cmd(CMD_RSVD_7, 32'h7FFF_FFFF);
		send_cmd(CMD_INS_R, 32'h7FFF_FFFF);
		send_cmd(CMD_INS_R, 32'h8000_0000);
		send_cmd(CMD_INS_R, 32'h0);
		send_cmd(CMD_PEEK_L, 32'h0);
		send_cmd(CMD_PEEK_R, 32'h0);
		send_cmd(CMD_DEL_R, 32'h0);
		send_cmd(CMD_DEL_L, 32'h0);
		send_cmd(CMD_DEL_L, 32'h0);

		write_mode(MODE_OUT_RESTR);
		send_cmd(CMD_DEL_R, 32'h0);
		send_cmd(CMD_INS_L, 32'hFFFF_FFFF);
		send_cmd(CMD_INS_L, 32'h1);
		send_cmd(CMD_INS_R, 32'h8000_0000);
		send_cmd(CMD_DEL_R, 32'h0);
		send_cmd(CMD_PEEK_L, 32'h0);
		send_cmd(CMD_PEEK_R, 32'h0);
		repeat (3) send_cmd(CMD_DEL_L, 32'h0);

		run_random(PHASE_ITEMS, MODE_IN_RESTR, -1);
		run_random(PHASE_ITEMS, MODE_OUT_RESTR, 40);
		run_random(PHASE_ITEMS, MODE_IN_RESTR, -1);
		idle_on = 1'b0;
		run_random(PHASE_ITEMS, MODE_OUT_RESTR, -1);

		drain();
		$display("%0d commands over %0d mode writes, %0d results checked",
			items_sent, mode_writes, checked);
		$display("%0d overflow, %0d underflow, %0d rejected, %0d full answers",
			overflow_cnt, underflow_cnt, reject_cnt, full_cnt);
		if (fail_count == 0)
			$display("restricted_circular_deque verification clean");
		else
			$display("restricted_circular_deque verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/rcd_pkg.sv
sv/rcd_if.sv
sv/rcd_mem.sv
sv/rcd_ctrl.sv
sv/restricted_circular_deque.sv
verif/deque_checker.sv
verif/testbench.sv
